// File: sv/rlfq_pkg.sv
package rlfq_pkg;

  // line buffer and queue geometry
  localparam int LINE_SIZE   = 64;
  localparam int QUEUE_SLOTS = 9;
  localparam int IDX_W       = $clog2(LINE_SIZE);
  localparam int SLOT_W      = $clog2(QUEUE_SLOTS);
  localparam int STORE_DEPTH = QUEUE_SLOTS << IDX_W;
  localparam int STORE_AW    = SLOT_W + IDX_W;

  // operation codes
  localparam logic [1:0] OP_RX     = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_ERROR  = 2'd2;
  localparam logic [1:0] OP_STATUS = 2'd3;

  // line terminators and error bits
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam int         OVERRUN_BIT = 3;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [IDX_W-1:0]  idx_t;

endpackage

// File: sv/rx_line_framer_queue.sv
// Receive line framer with a queue of finished lines.
// Commands enter on start/busy: a command beat is taken at a clock edge with
// start high and busy low. in_op selects receive byte, pop line, error event
// or status query. Every command yields one or more result beats, each shown
// for one cycle with out_strobe high; the receiver cannot stall them, and
// out_last marks the final beat of a command.
// Receive, error and status commands yield a single beat; their result appears in
// the cycle after the command is taken, and a new command can be taken then.
// A pop with zero capacity or an empty queue behaves the same way.
// Any other pop reads the slot length from its memory first. A line that does
// not fit the capacity, or is empty, gives a single beat; any other line is
// streamed from the line store one character per cycle, the store's single
// read port setting the streaming rate.
// Bytes are written straight into the free slot of the ring, so finishing a
// line is a pointer update and needs no copy.
// Status outputs show the counters as they stand after the command.
// Reset clears pointers, counters and flags; both memories hold no valid data
// after reset and need no clearing pass.
module rx_line_framer_queue
  import rlfq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_byte_in,
  input  logic [6:0]  in_pop_capacity,
  input  logic [4:0]  in_error_code,
  output logic        out_strobe,
  output logic [7:0]  out_char_out,
  output logic        out_char_valid,
  output logic        out_line_valid,
  output logic        out_last,
  output logic [5:0]  out_line_length,
  output logic [3:0]  out_queue_count,
  output logic [31:0] out_drop_count,
  output logic [31:0] out_long_line_count,
  output logic [31:0] out_error_count,
  output logic [31:0] out_overrun_count,
  output logic [4:0]  out_error_flags
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LEN  = 2'd1;
  localparam logic [1:0] S_STR  = 2'd2;

  logic [1:0]  state_r, state_nxt;
  idx_t        plen_r, plen_nxt;
  logic        ovf_r, ovf_nxt;
  slot_t       wslot_r, wslot_nxt;
  slot_t       rslot_r, rslot_nxt;
  logic [31:0] drops_r, drops_nxt;
  logic [31:0] longs_r, longs_nxt;
  logic [31:0] errs_r, errs_nxt;
  logic [31:0] ovrs_r, ovrs_nxt;
  logic [4:0]  flags_r, flags_nxt;
  logic [6:0]  cap_r, cap_nxt;
  idx_t        len_r, len_nxt;
  idx_t        idx_r, idx_nxt;
  slot_t       row_r, row_nxt;

  logic        strobe_r, strobe_nxt;
  logic [7:0]  char_r, char_nxt;
  logic        cv_r, cv_nxt;
  logic        lv_r, lv_nxt;
  logic        last_r, last_nxt;
  logic [5:0]  olen_r, olen_nxt;

  logic                st_we;
  logic [STORE_AW-1:0] st_waddr, st_raddr;
  logic [7:0]          st_wdata, st_rdata;
  logic                sl_we;
  logic [SLOT_W-1:0]   sl_waddr, sl_raddr;
  logic [IDX_W-1:0]    sl_wdata, sl_rdata;

  logic  accept;
  slot_t wslot_inc, rslot_inc;
  logic  is_eol;
  logic  str_last;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign wslot_inc = (32'(wslot_r) + 1 >= QUEUE_SLOTS) ? '0 : slot_t'(wslot_r + 1'b1);
  assign rslot_inc = (32'(rslot_r) + 1 >= QUEUE_SLOTS) ? '0 : slot_t'(rslot_r + 1'b1);
  assign is_eol    = (in_byte_in == CHAR_CR) || (in_byte_in == CHAR_LF);
  assign str_last  = (idx_t'(idx_r + 1'b1) == len_r);

  // line store: bytes land in the free slot, pops read the oldest slot
  rlfq_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // slot lengths
  rlfq_ram #(.WIDTH(IDX_W), .DEPTH(QUEUE_SLOTS)) u_lens (
    .clk   (clk),
    .we    (sl_we),
    .waddr (sl_waddr),
    .wdata (sl_wdata),
    .raddr (sl_raddr),
    .rdata (sl_rdata)
  );

  // command sequencer
  always_comb begin
    state_nxt  = state_r;
    plen_nxt   = plen_r;
    ovf_nxt    = ovf_r;
    wslot_nxt  = wslot_r;
    rslot_nxt  = rslot_r;
    drops_nxt  = drops_r;
    longs_nxt  = longs_r;
    errs_nxt   = errs_r;
    ovrs_nxt   = ovrs_r;
    flags_nxt  = flags_r;
    cap_nxt    = cap_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    row_nxt    = row_r;
    strobe_nxt = 1'b0;
    char_nxt   = '0;
    cv_nxt     = 1'b0;
    lv_nxt     = 1'b0;
    last_nxt   = 1'b1;
    olen_nxt   = '0;
    st_we      = 1'b0;
    st_waddr   = {wslot_r, plen_r};
    st_wdata   = in_byte_in;
    st_raddr   = {row_r, idx_t'(idx_r + 1'b1)};
    sl_we      = 1'b0;
    sl_waddr   = wslot_r;
    sl_wdata   = ovf_r ? '0 : plen_r;
    sl_raddr   = rslot_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          strobe_nxt = 1'b1;
          case (in_op)
            OP_RX: begin
              if (is_eol) begin
                if (plen_r != '0 || ovf_r) begin
                  if (wslot_inc == rslot_r) begin
                    drops_nxt = drops_r + 32'd1;
                  end else begin
                    sl_we     = 1'b1;
                    wslot_nxt = wslot_inc;
                  end
                  plen_nxt = '0;
                  ovf_nxt  = 1'b0;
                end
              end else if (!ovf_r) begin
                if (32'(plen_r) < LINE_SIZE - 1) begin
                  st_we    = 1'b1;
                  plen_nxt = idx_t'(plen_r + 1'b1);
                end else begin
                  ovf_nxt   = 1'b1;
                  longs_nxt = longs_r + 32'd1;
                end
              end
            end
            OP_ERROR: begin
              errs_nxt  = errs_r + 32'd1;
              flags_nxt = flags_r | in_error_code;
              if (in_error_code[OVERRUN_BIT]) begin
                ovrs_nxt = ovrs_r + 32'd1;
              end
              plen_nxt = '0;
              ovf_nxt  = 1'b1;
            end
            OP_POP: begin
              if (in_pop_capacity != '0 && rslot_r != wslot_r) begin
                strobe_nxt = 1'b0;
                cap_nxt    = in_pop_capacity;
                state_nxt  = S_LEN;
              end
            end
            default: ;
          endcase
        end
      end
      S_LEN: begin
        rslot_nxt = rslot_inc;
        row_nxt   = rslot_r;
        len_nxt   = sl_rdata;
        idx_nxt   = '0;
        st_raddr  = {rslot_r, idx_t'(0)};
        if ({1'b0, sl_rdata} >= cap_r || sl_rdata == '0) begin
          strobe_nxt = 1'b1;
          lv_nxt     = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_STR;
        end
      end
      S_STR: begin
        strobe_nxt = 1'b1;
        char_nxt   = st_rdata;
        cv_nxt     = 1'b1;
        lv_nxt     = 1'b1;
        last_nxt   = str_last;
        olen_nxt   = 6'(len_r);
        idx_nxt    = idx_t'(idx_r + 1'b1);
        if (str_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      plen_r   <= '0;
      ovf_r    <= 1'b0;
      wslot_r  <= '0;
      rslot_r  <= '0;
      drops_r  <= '0;
      longs_r  <= '0;
      errs_r   <= '0;
      ovrs_r   <= '0;
      flags_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      plen_r   <= plen_nxt;
      ovf_r    <= ovf_nxt;
      wslot_r  <= wslot_nxt;
      rslot_r  <= rslot_nxt;
      drops_r  <= drops_nxt;
      longs_r  <= longs_nxt;
      errs_r   <= errs_nxt;
      ovrs_r   <= ovrs_nxt;
      flags_r  <= flags_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cap_r  <= cap_nxt;
    len_r  <= len_nxt;
    idx_r  <= idx_nxt;
    row_r  <= row_nxt;
    char_r <= char_nxt;
    cv_r   <= cv_nxt;
    lv_r   <= lv_nxt;
    last_r <= last_nxt;
    olen_r <= olen_nxt;
  end

  // result beat
  assign out_strobe          = strobe_r;
  assign out_char_out        = char_r;
  assign out_char_valid      = cv_r;
  assign out_line_valid      = lv_r;
  assign out_last            = last_r;
  assign out_line_length     = olen_r;
  assign out_queue_count     = (wslot_r >= rslot_r) ? 4'(wslot_r - rslot_r)
                                                    : 4'(32'(wslot_r) + QUEUE_SLOTS
                                                         - 32'(rslot_r));
  assign out_drop_count      = drops_r;
  assign out_long_line_count = longs_r;
  assign out_error_count     = errs_r;
  assign out_overrun_count   = ovrs_r;
  assign out_error_flags     = flags_r;

  // checks
  a_slots_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(wslot_r) < QUEUE_SLOTS && 32'(rslot_r) < QUEUE_SLOTS)
    else $error("ring pointer out of range");

  a_plen_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(plen_r) < LINE_SIZE)
    else $error("partial length beyond line buffer");

  a_len_queue_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LEN |-> rslot_r != wslot_r)
    else $error("pop length read on empty queue");

  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_op != OP_POP |=> out_strobe && out_last && state_r == S_IDLE)
    else $error("single beat command missing its result");

  a_stream_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_STR && str_last |=> out_strobe && out_last && state_r == S_IDLE)
    else $error("line stream did not end on its last character");

endmodule

// File: sv/rlfq_ram.sv
module rlfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: tb/tb_top.sv
module tb_top;
  import rlfq_pkg::*;

  // one result beat as the block should show it
  typedef struct {
    logic [7:0]  char_out;
    logic        char_valid;
    logic        line_valid;
    logic        last;
    logic [5:0]  line_length;
    logic [3:0]  queue_count;
    logic [31:0] drop_count;
    logic [31:0] long_line_count;
    logic [31:0] error_count;
    logic [31:0] overrun_count;
    logic [4:0]  error_flags;
  } beat_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_op;
  logic [7:0]  in_byte_in;
  logic [6:0]  in_pop_capacity;
  logic [4:0]  in_error_code;
  logic        out_strobe;
  logic [7:0]  out_char_out;
  logic        out_char_valid;
  logic        out_line_valid;
  logic        out_last;
  logic [5:0]  out_line_length;
  logic [3:0]  out_queue_count;
  logic [31:0] out_drop_count;
  logic [31:0] out_long_line_count;
  logic [31:0] out_error_count;
  logic [31:0] out_overrun_count;
  logic [4:0]  out_error_flags;

  rx_line_framer_queue DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_op               (in_op),
    .in_byte_in          (in_byte_in),
    .in_pop_capacity     (in_pop_capacity),
    .in_error_code       (in_error_code),
    .out_strobe          (out_strobe),
    .out_char_out        (out_char_out),
    .out_char_valid      (out_char_valid),
    .out_line_valid      (out_line_valid),
    .out_last            (out_last),
    .out_line_length     (out_line_length),
    .out_queue_count     (out_queue_count),
    .out_drop_count      (out_drop_count),
    .out_long_line_count (out_long_line_count),
    .out_error_count     (out_error_count),
    .out_overrun_count   (out_overrun_count),
    .out_error_flags     (out_error_flags)
  );

  // framer and ring state as predicted
  logic [7:0]  part_buf [LINE_SIZE];
  int unsigned part_len;
  bit          part_ovf;
  logic [7:0]  ring_chars [QUEUE_SLOTS][LINE_SIZE];
  int unsigned ring_len [QUEUE_SLOTS];
  int unsigned wr_ptr;
  int unsigned rd_ptr;
  logic [31:0] n_drops;
  logic [31:0] n_long;
  logic [31:0] n_errors;
  logic [31:0] n_overruns;
  logic [4:0]  seen_flags;

  beat_t pending_beats [$];

  int  fails;
  int  cmds_sent;
  int  beats_checked;
  int  lines_streamed;
  bit  idle_on;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int unsigned slot_after(int unsigned s);
    return (s + 1 >= QUEUE_SLOTS) ? 0 : s + 1;
  endfunction

  function automatic int unsigned lines_held();
    return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : wr_ptr + QUEUE_SLOTS - rd_ptr;
  endfunction

  function automatic void queue_beat(logic [7:0] ch, logic cv, logic lv, logic lst,
                                     logic [5:0] len);
    beat_t b;
    b.char_out        = ch;
    b.char_valid      = cv;
    b.line_valid      = lv;
    b.last            = lst;
    b.line_length     = len;
    b.queue_count     = 4'(lines_held());
    b.drop_count      = n_drops;
    b.long_line_count = n_long;
    b.error_count     = n_errors;
    b.overrun_count   = n_overruns;
    b.error_flags     = seen_flags;
    pending_beats.push_back(b);
  endfunction

  // one received character into the framer
  function automatic void frame_byte(logic [7:0] ch);
    int unsigned nxt;
    int unsigned len;
    if (ch == CHAR_CR || ch == CHAR_LF) begin
      if (part_len != 0 || part_ovf) begin
        nxt = slot_after(wr_ptr);
        if (nxt == rd_ptr) begin
          n_drops = n_drops + 1;
        end else begin
          len = part_ovf ? 0 : part_len;
          for (int i = 0; i < len; i++) ring_chars[wr_ptr][i] = part_buf[i];
          ring_len[wr_ptr] = len;
          wr_ptr = nxt;
        end
        part_len = 0;
        part_ovf = 1'b0;
      end
    end else if (!part_ovf) begin
      if (part_len < LINE_SIZE - 1) begin
        part_buf[part_len] = ch;
        part_len++;
      end else begin
        part_ovf = 1'b1;
        n_long = n_long + 1;
      end
    end
  endfunction

  // expected beats of one accepted command
  function automatic void predict_beats(logic [1:0] op, logic [7:0] ch, logic [6:0] cap,
                                        logic [4:0] code);
    int unsigned slot;
    int unsigned len;
    case (op)
      OP_RX: begin
        frame_byte(ch);
      end
      OP_ERROR: begin
        n_errors   = n_errors + 1;
        seen_flags = seen_flags | code;
        if (code[OVERRUN_BIT]) n_overruns = n_overruns + 1;
        part_len = 0;
        part_ovf = 1'b1;
      end
      OP_POP: begin
        if (cap != 0 && rd_ptr != wr_ptr) begin
          slot   = rd_ptr;
          len    = ring_len[slot];
          rd_ptr = slot_after(slot);
          if (len >= cap || len == 0) begin
            queue_beat(8'h00, 1'b0, 1'b1, 1'b1, 6'd0);
          end else begin
            lines_streamed++;
            for (int i = 0; i < len; i++)
              queue_beat(ring_chars[slot][i], 1'b1, 1'b1, (i + 1 == len), 6'(len));
          end
          return;
        end
      end
      default: ;
    endcase
    queue_beat(8'h00, 1'b0, 1'b0, 1'b1, 6'd0);
  endfunction

  // result checker: every strobed beat against the oldest expectation
  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    beat_t e;
    if (rst_n && out_strobe) begin
      if (pending_beats.size() == 0) begin
        $error("result beat with nothing expected");
        fails++;
      end else begin
        e = pending_beats.pop_front();
        beats_checked++;
        check_field("char_out", e.char_out, out_char_out);
        check_field("char_valid", e.char_valid, out_char_valid);
        check_field("line_valid", e.line_valid, out_line_valid);
        check_field("last", e.last, out_last);
        check_field("line_length", e.line_length, out_line_length);
        check_field("queue_count", e.queue_count, out_queue_count);
        check_field("drop_count", e.drop_count, out_drop_count);
        check_field("long_line_count", e.long_line_count, out_long_line_count);
        check_field("error_count", e.error_count, out_error_count);
        check_field("overrun_count", e.overrun_count, out_overrun_count);
        check_field("error_flags", e.error_flags, out_error_flags);
      end
    end
  end

  // drive one command beat and wait for it to be taken
  task automatic send_cmd(logic [1:0] op, logic [7:0] ch, logic [6:0] cap, logic [4:0] code);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    @(negedge clk);
    repeat (gap) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start           <= 1'b1;
    in_op           <= op;
    in_byte_in      <= ch;
    in_pop_capacity <= cap;
    in_error_code   <= code;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_beats(op, ch, cap, code);
    cmds_sent++;
  endtask

  task automatic send_byte(logic [7:0] ch);
    send_cmd(OP_RX, ch, 7'($urandom_range(0, 64)), 5'($urandom));
  endtask

  task automatic send_pop(logic [6:0] cap);
    send_cmd(OP_POP, 8'($urandom), cap, 5'($urandom));
  endtask

  task automatic send_error(logic [4:0] code);
    send_cmd(OP_ERROR, 8'($urandom), 7'($urandom_range(0, 64)), code);
  endtask

  task automatic send_status();
    send_cmd(OP_STATUS, 8'($urandom), 7'($urandom_range(0, 64)), 5'($urandom));
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == CHAR_CR || b == CHAR_LF);
    return b;
  endfunction

  // a line of len characters closed by term
  task automatic send_line(int len, logic [7:0] term);
    for (int i = 0; i < len; i++) send_byte(text_byte());
    send_byte(term);
  endtask

  // lower start, then hold off until every expected beat has come
  task automatic wait_quiet();
    int guard;
    guard = 0;
    @(negedge clk);
    start <= 1'b0;
    while (pending_beats.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_beats.size() != 0) begin
      $error("%0d result beats never arrived", pending_beats.size());
      fails++;
      pending_beats.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  // status and pops with nothing queued or with zero capacity
  task automatic test_idle_queries();
    send_status();
    send_pop(7'd64);
    send_pop(7'd0);
    send_line(3, CHAR_LF);
    send_pop(7'd0);
    send_status();
  endtask

  // short lines, edge characters, fit and no-fit pops, ignored empty lines
  task automatic test_short_lines();
    send_pop(7'd64);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
    send_pop(7'd3);
    send_line(4, CHAR_CR);
    send_pop(7'd4);
    send_line(4, CHAR_LF);
    send_pop(7'd5);
    send_line(1, CHAR_LF);
    send_pop(7'd2);
  endtask

  // longest line that fits, then one that overflows well past the buffer
  task automatic test_long_lines();
    send_line(LINE_SIZE - 1, CHAR_LF);
    send_pop(7'd64);
    send_line(LINE_SIZE + 5, CHAR_LF);
    send_status();
    send_pop(7'd1);
  endtask

  // error events drop the partial line and leave an empty line behind
  task automatic test_error_events();
    send_byte(text_byte());
    send_byte(text_byte());
    send_error(5'h00);
    send_byte(CHAR_LF);
    send_pop(7'd64);
    send_error(5'h08);
    send_error(5'h17);
    send_error(5'h1F);
    send_byte(CHAR_CR);
    send_byte(CHAR_CR);
    send_line(2, CHAR_LF);
    send_pop(7'd64);
    send_pop(7'd64);
  endtask

  // ring fills at QUEUE_SLOTS-1 lines, the lines after that are dropped
  task automatic test_queue_full();
    for (int i = 0; i < QUEUE_SLOTS + 1; i++) send_line(1 + (i % 3), CHAR_LF);
    send_pop(7'd0);
    send_status();
    for (int i = 0; i < QUEUE_SLOTS; i++) send_pop(7'd64);
  endtask

  // mostly well-formed lines with random content, mixed with pops, errors, status queries and noise
  task automatic test_random(int n_items);
    int first;
    int pick;
    int len;
    int c;
    first = cmds_sent;
    while (cmds_sent - first < n_items) begin
      if (cmds_sent - first > n_items - 30) idle_on = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        c = $urandom_range(0, 99);
        if (c < 12)      len = 0;
        else if (c < 77) len = $urandom_range(1, 8);
        else if (c < 94) len = $urandom_range(9, 40);
        else             len = $urandom_range(LINE_SIZE - 3, LINE_SIZE + 3);
        send_line(len, $urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
        if ($urandom_range(0, 5) == 0) send_byte(CHAR_LF);
      end else if (pick < 75) begin
        c = $urandom_range(0, 9);
        if (c == 0)     send_pop(7'd0);
        else if (c < 4) send_pop(7'd64);
        else            send_pop(7'($urandom_range(1, 64)));
      end else if (pick < 84) begin
        send_error(5'($urandom));
      end else if (pick < 91) begin
        send_status();
      end else begin
        send_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_op           = OP_STATUS;
    in_byte_in      = 8'h00;
    in_pop_capacity = 7'd0;
    in_error_code   = 5'd0;
    fails           = 0;
    cmds_sent       = 0;
    beats_checked   = 0;
    lines_streamed  = 0;
    idle_on         = 1'b1;
    part_len        = 0;
    part_ovf        = 1'b0;
    wr_ptr          = 0;
    rd_ptr          = 0;
    n_drops         = '0;
    n_long          = '0;
    n_errors        = '0;
    n_overruns      = '0;
    seen_flags      = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_queries();
    test_short_lines();
    test_long_lines();
    wait_quiet();
    test_error_events();
    test_queue_full();
    wait_quiet();
    test_random(100);
    wait_quiet();
    repeat (10) @(posedge clk);

    $display("Ran %0d commands, checked %0d result beats, streamed %0d lines.",
             cmds_sent, beats_checked, lines_streamed);
    $display("Saw %0d dropped lines, %0d long lines, %0d error events.",
             n_drops, n_long, n_errors);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
